>>> src/rrsp_pkg.sv
// ----------------------------------------------------------------------------
// rrsp_pkg
// Types, codes and helpers shared by the reply stream parser modules.
// ----------------------------------------------------------------------------
package rrsp_pkg;

   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   localparam logic [15:0] MAX_ELEM_RESET = 16'd1024;
   localparam logic [63:0] POS_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;
   localparam int          CHILD_W = 16;

   typedef enum logic [2:0] {
      PH_TYPE    = 3'd0,
      PH_LINE    = 3'd1,
      PH_NUMBER  = 3'd2,
      PH_DATA    = 3'd3,
      PH_TRAILER = 3'd4
   } phase_type;

   localparam logic [2:0] T_STATUS  = 3'd0;
   localparam logic [2:0] T_ERRLINE = 3'd1;
   localparam logic [2:0] T_INTEGER = 3'd2;
   localparam logic [2:0] T_BULK    = 3'd3;
   localparam logic [2:0] T_ARRAY   = 3'd4;

   localparam logic [1:0] EV_PAYLOAD  = 2'd0;
   localparam logic [1:0] EV_COMPLETE = 2'd1;
   localparam logic [1:0] EV_ERROR    = 2'd2;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TYPE     = 3'd1;
   localparam logic [2:0] ERR_NUMBER   = 3'd2;
   localparam logic [2:0] ERR_DEPTH    = 3'd3;
   localparam logic [2:0] ERR_ELEMENTS = 3'd4;

   typedef enum logic [2:0] {
      SC_NONE     = 3'd0,
      SC_PAY1     = 3'd1,
      SC_PAY2     = 3'd2,
      SC_FAIL     = 3'd3,
      SC_COMPLETE = 3'd4,
      SC_PUSH     = 3'd5
   } step_class_type;

   typedef enum logic [2:0] {
      CS_IDLE   = 3'd0,
      CS_EXEC   = 3'd1,
      CS_EMIT   = 3'd2,
      CS_EMIT2  = 3'd3,
      CS_POP_RD = 3'd4,
      CS_POP_WR = 3'd5
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic emit_hold;
      logic emit_byte2;
      logic pop_rd;
      logic pop_wr;
   } cmd_type;

   typedef struct packed {
      step_class_type cls;
      logic           lvl_zero;
      logic           pop_stop;
      logic           pop_last;
      logic           rsp_free;
   } status_type;

   function automatic logic [63:0] sat_digit(input logic [63:0] acc, input logic neg,
                                             input logic [7:0] c);
      logic [67:0] sum;
      logic [67:0] cap;
      sum = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {60'b0, c - CH_ZERO};
      cap = {4'b0, (neg ? NEG_CAP : POS_CAP)};
      return (sum > cap) ? cap[63:0] : sum[63:0];
   endfunction

endpackage

>>> src/resp_reply_stream_parser_core.sv
// ----------------------------------------------------------------------------
// resp_reply_stream_parser_core
// Byte-serial parser for nested RESP2 replies with per-level child counts.
//
//   channel  direction  signals
//   req      in         req_valid/req_ready, req_action, req_data_byte
//   rsp      out        rsp_valid/rsp_ready, event fields (up to two per item)
//   csr      in         csr_wr_en, csr_wr_data (max elements per reply)
//
// An item with no result returns from execute to idle; each result passes
// through an emit state. An element completion first pops nesting levels
// through the child-count stack RAM (one read, one write-back per level).
// Synchronous reset; no clearing pass. A stalled rsp side holds the sequencer
// in its emit state; one finished item may wait while the next is accepted.
// ----------------------------------------------------------------------------
module resp_reply_stream_parser_core import rrsp_pkg::*; #(
   parameter int MAX_NESTING = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_kind,
   output logic [2:0]         rsp_element_type,
   output logic signed [63:0] rsp_element_value,
   output logic [7:0]         rsp_payload_byte,
   output logic [3:0]         rsp_nest_level,
   output logic               rsp_reply_done,
   output logic [2:0]         rsp_error_code,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   rrsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrsp_dpath #(
      .MAX_NESTING (MAX_NESTING)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_element_type  (rsp_element_type),
      .rsp_element_value (rsp_element_value),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_nest_level    (rsp_nest_level),
      .rsp_reply_done    (rsp_reply_done),
      .rsp_error_code    (rsp_error_code)
   );

endmodule

>>> src/rrsp_ram.sv
// ----------------------------------------------------------------------------
// rrsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rrsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/rrsp_ctrl.sv
// ----------------------------------------------------------------------------
// rrsp_ctrl
// Sequencer: runs one item through execute, result emission and stack pop.
// ----------------------------------------------------------------------------
module rrsp_ctrl import rrsp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic           two_ff, two_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         two_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         two_ff   <= two_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      two_in   = two_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_EXEC;
         end
         CS_EXEC: begin
            two_in = (status.cls == SC_PAY2);
            unique case (status.cls)
               SC_NONE:     state_in = CS_IDLE;
               SC_COMPLETE: state_in = status.lvl_zero ? CS_EMIT : CS_POP_RD;
               default:     state_in = CS_EMIT;
            endcase
         end
         CS_EMIT: begin
            if (status.rsp_free) state_in = two_ff ? CS_EMIT2 : CS_IDLE;
         end
         CS_EMIT2: begin
            if (status.rsp_free) state_in = CS_IDLE;
         end
         CS_POP_RD: state_in = CS_POP_WR;
         CS_POP_WR: begin
            state_in = (status.pop_stop || status.pop_last) ? CS_EMIT : CS_POP_RD;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_ready  = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         CS_EXEC:   cmd.commit     = 1'b1;
         CS_EMIT:   cmd.emit_hold  = status.rsp_free;
         CS_EMIT2:  cmd.emit_byte2 = status.rsp_free;
         CS_POP_RD: cmd.pop_rd     = 1'b1;
         CS_POP_WR: cmd.pop_wr     = 1'b1;
         default:   cmd            = '0;
      endcase
   end

endmodule

>>> src/rrsp_dpath.sv
// ----------------------------------------------------------------------------
// rrsp_dpath
// Parser state, number accumulator, child-count stack and result register.
// ----------------------------------------------------------------------------
module rrsp_dpath import rrsp_pkg::*; #(
   parameter int MAX_NESTING = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_action,
   input  logic [7:0]         req_data_byte,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_kind,
   output logic [2:0]         rsp_element_type,
   output logic signed [63:0] rsp_element_value,
   output logic [7:0]         rsp_payload_byte,
   output logic [3:0]         rsp_nest_level,
   output logic               rsp_reply_done,
   output logic [2:0]         rsp_error_code
);

   localparam int LVL_W = $clog2(MAX_NESTING);

   // item and parser state
   logic             act_ff;
   logic [7:0]       byte_ff;
   logic [15:0]      max_ff;
   phase_type        phase_ff, phase_in;
   logic [2:0]       type_ff, type_in;
   logic [63:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in, bad_ff, bad_in, seen_ff, seen_in, pend_ff, pend_in;
   logic [63:0]      rem_ff, rem_in;
   logic [31:0]      len_ff, len_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [15:0]      eu_ff, eu_in;
   // held result
   logic [1:0]       hk_ff, hk_in;
   logic [2:0]       ht_ff, ht_in;
   logic [63:0]      hv_ff, hv_in;
   logic [7:0]       hp_ff, hp_in;
   logic [LVL_W-1:0] hl_ff;
   logic [2:0]       he_ff, he_in;
   logic             done_ff;
   // result register
   logic             rv_ff;
   logic [1:0]       rk_ff;
   logic [2:0]       rt_ff, re_ff;
   logic [63:0]      rval_ff;
   logic [7:0]       rp_ff;
   logic [LVL_W-1:0] rl_ff;
   logic             rd_ff;

   step_class_type   cls;
   logic [31:0]      len1, len2;
   logic             is_digit, neg_eff;
   logic [63:0]      v;
   logic [64:0]      eu_sum;
   logic [LVL_W:0]   lvl_next;
   logic [LVL_W-1:0] lvl_dn;
   logic             push;
   logic [CHILD_W-1:0] child_rd, child_dec;
   logic [LVL_W+3:0] lvl_ext;

   assign len1     = (len_ff == 32'hFFFF_FFFF) ? len_ff : len_ff + 32'd1;
   assign len2     = (len1 == 32'hFFFF_FFFF) ? len1 : len1 + 32'd1;
   assign is_digit = (byte_ff >= CH_ZERO) && (byte_ff <= CH_NINE);
   assign neg_eff  = neg_ff && (acc_ff != 64'd0);
   assign v        = neg_eff ? (64'd0 - acc_ff) : acc_ff;
   assign eu_sum   = {1'b0, v} + {49'b0, eu_ff};
   assign lvl_next = {1'b0, level_ff} + 1'b1;
   assign lvl_dn   = level_ff - 1'b1;

   always_comb begin
      cls      = SC_NONE;
      phase_in = phase_ff;
      type_in  = type_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      bad_in   = bad_ff;
      seen_in  = seen_ff;
      pend_in  = pend_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      eu_in    = eu_ff;
      hk_in    = EV_PAYLOAD;
      ht_in    = type_ff;
      hv_in    = 64'd0;
      hp_in    = byte_ff;
      he_in    = ERR_NONE;
      if (!act_ff) begin
         unique case (phase_ff)
            PH_LINE: begin
               if (pend_ff) begin
                  pend_in = 1'b0;
                  if (byte_ff == CH_LF) begin
                     cls   = SC_COMPLETE;
                     hv_in = {32'b0, len_ff};
                  end else if (byte_ff == CH_CR) begin
                     cls     = SC_PAY1;
                     hp_in   = CH_CR;
                     pend_in = 1'b1;
                     len_in  = len1;
                  end else begin
                     cls    = SC_PAY2;
                     hp_in  = CH_CR;
                     len_in = len2;
                  end
               end else if (byte_ff == CH_CR) begin
                  pend_in = 1'b1;
               end else begin
                  cls    = SC_PAY1;
                  len_in = len1;
               end
            end
            PH_NUMBER: begin
               if (pend_ff && byte_ff != CH_LF) begin
                  bad_in  = 1'b1;
                  pend_in = (byte_ff == CH_CR);
               end else if (pend_ff) begin
                  pend_in = 1'b0;
                  if (bad_ff || !seen_ff) begin
                     cls   = SC_FAIL;
                     he_in = ERR_NUMBER;
                  end else if (type_ff == T_INTEGER ||
                               (type_ff == T_BULK && neg_eff) ||
                               (type_ff == T_ARRAY && (neg_eff || v == 64'd0))) begin
                     cls   = SC_COMPLETE;
                     hv_in = v;
                  end else if (type_ff == T_BULK) begin
                     acc_in   = v;
                     rem_in   = v;
                     phase_in = (v == 64'd0) ? PH_TRAILER : PH_DATA;
                  end else if (eu_sum > {49'b0, max_ff}) begin
                     cls   = SC_FAIL;
                     he_in = ERR_ELEMENTS;
                  end else if (lvl_next >= (LVL_W+1)'(MAX_NESTING)) begin
                     cls   = SC_FAIL;
                     he_in = ERR_DEPTH;
                  end else begin
                     cls      = SC_PUSH;
                     hk_in    = EV_COMPLETE;
                     hv_in    = v;
                     eu_in    = eu_sum[15:0];
                     phase_in = PH_TYPE;
                  end
               end else if (byte_ff == CH_CR) begin
                  pend_in = 1'b1;
               end else begin
                  if (len_ff == 32'd0 && (byte_ff == CH_PLUS || byte_ff == CH_MINUS)) begin
                     neg_in = (byte_ff == CH_MINUS);
                  end else if (is_digit) begin
                     acc_in  = sat_digit(acc_ff, neg_ff, byte_ff);
                     seen_in = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
                  len_in = len1;
               end
            end
            PH_DATA: begin
               cls    = SC_PAY1;
               rem_in = rem_ff - 64'd1;
               if (rem_ff == 64'd1) begin
                  phase_in = PH_TRAILER;
                  pend_in  = 1'b0;
               end
            end
            PH_TRAILER: begin
               pend_in = !pend_ff;
               if (pend_ff) begin
                  cls   = SC_COMPLETE;
                  hv_in = acc_ff;
               end
            end
            default: begin
               case (byte_ff)
                  CH_PLUS:   type_in = T_STATUS;
                  CH_MINUS:  type_in = T_ERRLINE;
                  CH_COLON:  type_in = T_INTEGER;
                  CH_DOLLAR: type_in = T_BULK;
                  CH_STAR:   type_in = T_ARRAY;
                  default: begin
                     cls   = SC_FAIL;
                     he_in = ERR_TYPE;
                  end
               endcase
               if (level_ff == '0) eu_in = 16'd1;
               len_in   = 32'd0;
               pend_in  = 1'b0;
               acc_in   = 64'd0;
               neg_in   = 1'b0;
               bad_in   = 1'b0;
               seen_in  = 1'b0;
               phase_in = (type_in == T_STATUS || type_in == T_ERRLINE) ? PH_LINE : PH_NUMBER;
            end
         endcase
      end
      if (cls == SC_COMPLETE) begin
         hk_in    = EV_COMPLETE;
         hp_in    = 8'd0;
         phase_in = PH_TYPE;
      end else if (cls == SC_PUSH) begin
         hp_in = 8'd0;
      end else if (cls == SC_FAIL) begin
         hk_in = EV_ERROR;
         ht_in = T_STATUS;
         hv_in = 64'd0;
         hp_in = 8'd0;
      end
   end

   assign push      = cmd.commit && (cls == SC_PUSH);
   assign child_dec = child_rd - 1'b1;

   rrsp_ram #(
      .WIDTH (CHILD_W),
      .DEPTH (MAX_NESTING)
   ) u_stack (
      .clock   (clock),
      .wr_en   (push || cmd.pop_wr),
      .wr_addr (push ? level_ff : lvl_dn),
      .wr_data (push ? v[CHILD_W-1:0] : child_dec),
      .rd_en   (cmd.pop_rd),
      .rd_addr (lvl_dn),
      .rd_data (child_rd)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_action;
         byte_ff <= req_data_byte;
      end
      if (cmd.commit) begin
         hk_ff <= hk_in;
         ht_ff <= ht_in;
         hv_ff <= hv_in;
         hp_ff <= hp_in;
         hl_ff <= level_ff;
         he_ff <= he_in;
      end
      if (cmd.emit_hold || cmd.emit_byte2) begin
         rk_ff   <= cmd.emit_hold ? hk_ff : EV_PAYLOAD;
         rt_ff   <= cmd.emit_hold ? ht_ff : type_ff;
         rval_ff <= cmd.emit_hold ? hv_ff : 64'd0;
         rp_ff   <= cmd.emit_hold ? hp_ff : byte_ff;
         rl_ff   <= cmd.emit_hold ? hl_ff : level_ff;
         re_ff   <= cmd.emit_hold ? he_ff : ERR_NONE;
         rd_ff   <= cmd.emit_hold && (hk_ff == EV_COMPLETE) && done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff   <= MAX_ELEM_RESET;
         rv_ff    <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_TYPE;
         type_ff  <= T_STATUS;
         acc_ff   <= 64'd0;
         neg_ff   <= 1'b0;
         bad_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         pend_ff  <= 1'b0;
         rem_ff   <= 64'd0;
         len_ff   <= 32'd0;
         level_ff <= '0;
         eu_ff    <= 16'd0;
      end else begin
         if (csr_wr_en) max_ff <= csr_wr_data;
         if (cmd.emit_hold || cmd.emit_byte2) begin
            rv_ff <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
         if (cmd.commit) begin
            done_ff <= (cls == SC_COMPLETE) && (level_ff == '0);
            if (act_ff || cls == SC_FAIL) begin
               phase_ff <= PH_TYPE;
               type_ff  <= T_STATUS;
               acc_ff   <= 64'd0;
               neg_ff   <= 1'b0;
               bad_ff   <= 1'b0;
               seen_ff  <= 1'b0;
               pend_ff  <= 1'b0;
               rem_ff   <= 64'd0;
               len_ff   <= 32'd0;
               level_ff <= '0;
               eu_ff    <= 16'd0;
            end else begin
               phase_ff <= phase_in;
               type_ff  <= type_in;
               acc_ff   <= acc_in;
               neg_ff   <= neg_in;
               bad_ff   <= bad_in;
               seen_ff  <= seen_in;
               pend_ff  <= pend_in;
               rem_ff   <= rem_in;
               len_ff   <= len_in;
               eu_ff    <= eu_in;
               if (push) level_ff <= lvl_next[LVL_W-1:0];
            end
         end
         if (cmd.pop_wr) begin
            done_ff <= (child_dec == '0) && (level_ff == LVL_W'(1));
            if (child_dec == '0) level_ff <= lvl_dn;
         end
         if (cmd.emit_hold && hk_ff == EV_COMPLETE && done_ff) begin
            level_ff <= '0;
            eu_ff    <= 16'd0;
         end
      end
   end

   assign lvl_ext = {4'b0, rl_ff};

   always_comb begin
      status          = '0;
      status.cls      = act_ff ? SC_NONE : cls;
      status.lvl_zero = (level_ff == '0);
      status.pop_stop = (child_dec != '0);
      status.pop_last = (level_ff == LVL_W'(1));
      status.rsp_free = !rv_ff || rsp_ready;
   end

   assign rsp_valid         = rv_ff;
   assign rsp_event_kind    = rk_ff;
   assign rsp_element_type  = rt_ff;
   assign rsp_element_value = rval_ff;
   assign rsp_payload_byte  = rp_ff;
   assign rsp_nest_level    = lvl_ext[3:0];
   assign rsp_reply_done    = rd_ff;
   assign rsp_error_code    = re_ff;

endmodule
